>>> design/pcmfc_pkg.sv
`default_nettype none
package pcmfc_pkg;

    typedef enum logic [2:0] {
        ENC_UNKNOWN = 3'd0,
        ENC_S16     = 3'd1,
        ENC_S24P    = 3'd2,
        ENC_S24W    = 3'd3,
        ENC_S32     = 3'd4,
        ENC_F32     = 3'd5
    } enc_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSUP   = 2'd2
    } status_t;

    localparam logic [0:0] REG_SRC = 1'b0;
    localparam logic [0:0] REG_DST = 1'b1;

    // byte count of an encoding, 0 when unknown
    function automatic logic [2:0] enc_bytes(input logic [2:0] e);
        logic [2:0] n;
        case (e)
            ENC_S16:                   n = 3'd2;
            ENC_S24P:                  n = 3'd3;
            ENC_S24W, ENC_S32, ENC_F32: n = 3'd4;
            default:                   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

>>> design/pcmfc_to_float.sv
`default_nettype none
// Signed 32-bit fraction (value / 2^31) to float32, round to nearest even.
module pcmfc_to_float
    import pcmfc_pkg::*;
(
    input  wire logic [31:0] a,
    output logic [31:0]      bits
);
    logic        sgn;
    logic [31:0] mag;
    logic [4:0]  msb;
    logic        found;
    logic [31:0] norm;
    logic [23:0] mant;
    logic        rnd;
    logic        sticky;
    logic [24:0] mant_r;
    logic [7:0]  expo;

    always_comb
    begin
        sgn = a[31];
        mag = sgn ? (~a + 32'd1) : a;
        // leading one position
        msb   = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && mag[i])
            begin
                msb   = 5'(i);
                found = 1'b1;
            end
        end
        norm   = mag << (5'd31 - msb);
        mant   = norm[31:8];
        rnd    = norm[7];
        sticky = |norm[6:0];
        mant_r = {1'b0, mant} + 25'(rnd & (sticky | mant[0]));
        // exponent: value = mag * 2^-31, leading bit at 2^(msb-31)
        expo   = 8'd96 + {3'b000, msb};
        if (mant_r[24])
            expo = expo + 8'd1;
        if (!found)
            bits = 32'd0;
        else
            bits = {sgn, expo, mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
    end
endmodule
`default_nettype wire

>>> design/pcmfc_convert.sv
`default_nettype none
// Combinational conversion of one sample word.
module pcmfc_convert
    import pcmfc_pkg::*;
(
    input  wire logic [2:0]  src_enc,
    input  wire logic [2:0]  dst_enc,
    input  wire logic [31:0] src_word,
    output logic [31:0]      dst_word,
    output logic [2:0]       dst_bytes,
    output logic [1:0]       status
);
    logic [2:0]  sb;
    logic [2:0]  db;
    logic [31:0] aligned;
    logic [31:0] fbits;
    logic [31:0] ival;

    pcmfc_to_float u_flt (
        .a    (aligned),
        .bits (fbits)
    );

    always_comb
    begin
        sb = enc_bytes(src_enc);
        db = enc_bytes(dst_enc);
        // left-align to signed 32
        case (src_enc)
            ENC_S16:            aligned = {src_word[15:0], 16'h0000};
            ENC_S24P, ENC_S24W: aligned = {src_word[23:0], 8'h00};
            ENC_S32:            aligned = src_word;
            default:            aligned = 32'd0;
        endcase
        case (dst_enc)
            ENC_S16:            ival = {16'h0000, aligned[31:16]};
            ENC_S24P, ENC_S24W: ival = {{8{aligned[31]}}, aligned[31:8]};
            default:            ival = aligned;
        endcase
        if (sb == 3'd0 || db == 3'd0)
        begin
            dst_word  = 32'd0;
            dst_bytes = 3'd0;
            status    = ST_INVALID;
        end
        else if (src_enc == ENC_F32 && dst_enc != ENC_F32)
        begin
            dst_word  = 32'd0;
            dst_bytes = 3'd0;
            status    = ST_NOSUP;
        end
        else
        begin
            dst_bytes = db;
            status    = ST_OK;
            if (src_enc == dst_enc)
                dst_word = src_word & byte_mask(db);
            else if (dst_enc == ENC_F32)
                dst_word = fbits;
            else
                dst_word = ival & byte_mask(db);
        end
    end
endmodule
`default_nettype wire

>>> design/pcm_sample_format_converter.sv
`default_nettype none
// PCM sample format converter. Takes one raw little-endian sample per
// transaction on s_axis and returns it re-encoded on m_axis, one result per
// input, in order. Encodings: 1 s16, 2 s24 packed, 3 s24 in 32, 4 s32,
// 5 float32; write source to register 0, destination to register 1 while
// idle. Throughput is one sample per cycle unless m_axis stalls; samples
// pass an input register, then a result register. Unknown encodings return
// status 1, float to integer returns status 2, both with zero data and zero bytes.
module pcm_sample_format_converter
    import pcmfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [2:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] src_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // [31:0] dst_word, [34:32] dst_bytes,
                                             // [36:35] status, [39:37] zero
);
    logic [2:0]  src_enc_reg;
    logic [2:0]  dst_enc_reg;
    logic        in_vld_reg;
    logic [31:0] in_word_reg;
    logic        out_vld_reg;
    logic [36:0] out_data_reg;
    logic        in_ready;
    logic        out_load;
    logic [31:0] c_word;
    logic [2:0]  c_bytes;
    logic [1:0]  c_status;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_enc_reg <= ENC_UNKNOWN;
            dst_enc_reg <= ENC_UNKNOWN;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SRC)
                src_enc_reg <= cfg_data;
            else
                dst_enc_reg <= cfg_data;
        end
    end

    // pipeline flow: stage advances when the next one is free
    assign out_load      = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign in_ready      = !in_vld_reg || out_load;
    assign s_axis_tready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= s_axis_tvalid;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
            in_word_reg <= s_axis_tdata;
        if (out_load)
            out_data_reg <= {c_status, c_bytes, c_word};
    end

    pcmfc_convert u_conv (
        .src_enc   (src_enc_reg),
        .dst_enc   (dst_enc_reg),
        .src_word  (in_word_reg),
        .dst_word  (c_word),
        .dst_bytes (c_bytes),
        .status    (c_status)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg};
endmodule
`default_nettype wire
